FILE: rtl/core/lksm_pkg.sv
// ----------------------------------------------------------------------------
// lksm_pkg
// Shared constants and types of the display and keypad serial master.
// ----------------------------------------------------------------------------
package lksm_pkg;

	localparam int DIGITS_PER_VALUE = 4;
	localparam int NUM_DIGITS       = 2 * DIGITS_PER_VALUE;
	localparam int DIG_IW           = $clog2(NUM_DIGITS);
	localparam int QDEPTH           = DIGITS_PER_VALUE + 3;
	localparam int QPTR_W           = $clog2(QDEPTH);
	localparam int QCNT_W           = $clog2(QDEPTH + 1);

	localparam logic [16:0] RECIP10 = 17'd52429;
	localparam int          RECIP_SH = 19;

	typedef struct packed {
		logic                       request_valid;
		logic [1:0]                 kind;
		logic [7:0]                 command_byte;
		logic [7:0]                 data_byte;
		logic                       key_line;
		logic [NUM_DIGITS-1:0][3:0] digits;
	} item_t;

	typedef struct packed {
		logic       select_n;
		logic       serial_clock;
		logic       serial_data;
		logic       drive_enable;
		logic       busy_res;
		logic       key_valid;
		logic [7:0] key_code;
		logic       request_dropped;
	} res_t;

endpackage

FILE: rtl/core/lksm_front.sv
// ----------------------------------------------------------------------------
// lksm_front
// Accepts ticks, takes magnitudes and splits both numbers into decimal digits.
// ----------------------------------------------------------------------------
module lksm_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        request_valid,
	input  logic [1:0]                  kind,
	input  logic [7:0]                  command_byte,
	input  logic [7:0]                  data_byte,
	input  logic signed [15:0]          value_a,
	input  logic signed [15:0]          value_b,
	input  logic                        key_line,
	input  logic                        q_rd,
	output logic                        q_wr,
	output lksm_pkg::item_t             q_item
);

	localparam int DPV = lksm_pkg::DIGITS_PER_VALUE;
	localparam int ND  = lksm_pkg::NUM_DIGITS;

	lksm_pkg::item_t                pipe_s [0:DPV];
	lksm_pkg::item_t                stage_n [1:DPV];
	logic [15:0]                    qa_s   [0:DPV];
	logic [15:0]                    qb_s   [0:DPV];
	logic [DPV:0]                   vld_s;
	logic [15:0]                    quo_a  [1:DPV];
	logic [15:0]                    quo_b  [1:DPV];
	logic [3:0]                     rem_a  [1:DPV];
	logic [3:0]                     rem_b  [1:DPV];
	logic [lksm_pkg::QCNT_W-1:0]    occ_q;
	logic                           accept;
	logic [32:0]                    prod_a [1:DPV];
	logic [32:0]                    prod_b [1:DPV];

	assign full   = (occ_q == lksm_pkg::QCNT_W'(lksm_pkg::QDEPTH));
	assign accept = push && !full;

	always_comb begin
		for (int k = 1; k <= DPV; k++) begin
			prod_a[k] = 33'(qa_s[k-1]) * 33'(lksm_pkg::RECIP10);
			prod_b[k] = 33'(qb_s[k-1]) * 33'(lksm_pkg::RECIP10);
			quo_a[k]  = 16'(prod_a[k] >> lksm_pkg::RECIP_SH);
			quo_b[k]  = 16'(prod_b[k] >> lksm_pkg::RECIP_SH);
			rem_a[k]  = 4'(qa_s[k-1] - ((quo_a[k] << 3) + (quo_a[k] << 1)));
			rem_b[k]  = 4'(qb_s[k-1] - ((quo_b[k] << 3) + (quo_b[k] << 1)));
			stage_n[k]                = pipe_s[k-1];
			stage_n[k].digits[DPV-k]  = rem_a[k];
			stage_n[k].digits[ND-k]   = rem_b[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			occ_q <= '0;
		end else begin
			vld_s <= {vld_s[DPV-1:0], accept};
			if (accept && !q_rd)
				occ_q <= occ_q + 1'b1;
			else if (!accept && q_rd)
				occ_q <= occ_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pipe_s[0].request_valid <= request_valid;
			pipe_s[0].kind          <= kind;
			pipe_s[0].command_byte  <= command_byte;
			pipe_s[0].data_byte     <= data_byte;
			pipe_s[0].key_line      <= key_line;
			pipe_s[0].digits        <= '0;
			qa_s[0] <= value_a[15] ? 16'(~value_a + 16'sd1) : 16'(value_a);
			qb_s[0] <= value_b[15] ? 16'(~value_b + 16'sd1) : 16'(value_b);
		end
		for (int k = 1; k <= DPV; k++) begin
			pipe_s[k] <= stage_n[k];
			qa_s[k]   <= quo_a[k];
			qb_s[k]   <= quo_b[k];
		end
	end

	assign q_wr   = vld_s[DPV];
	assign q_item = pipe_s[DPV];

`ifndef SYNTHESIS
	a_counted: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DPV] |-> occ_q != '0)
		else $error("item leaves digit pipeline without a credit");
`endif

endmodule

FILE: rtl/core/lksm_req_fifo.sv
// ----------------------------------------------------------------------------
// lksm_req_fifo
// Short request queue between the front part and the serial engine.
// ----------------------------------------------------------------------------
module lksm_req_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  lksm_pkg::item_t wr_item,
	input  logic            rd_en,
	output lksm_pkg::item_t rd_item,
	output logic            not_empty
);

	lksm_pkg::item_t               mem_q [lksm_pkg::QDEPTH];
	logic [lksm_pkg::QPTR_W-1:0]   wptr_q;
	logic [lksm_pkg::QPTR_W-1:0]   rptr_q;
	logic [lksm_pkg::QCNT_W-1:0]   cnt_q;

	localparam logic [lksm_pkg::QPTR_W-1:0] LAST = lksm_pkg::QPTR_W'(lksm_pkg::QDEPTH - 1);

	assign not_empty = (cnt_q != '0);
	assign rd_item   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en)
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
			if (rd_en)
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (!wr_en && rd_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_item;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |-> cnt_q != lksm_pkg::QCNT_W'(lksm_pkg::QDEPTH))
		else $error("request queue overflow");
`endif

endmodule

FILE: rtl/core/lksm_back.sv
// ----------------------------------------------------------------------------
// lksm_back
// Serial pin engine: phase sequencer, digit store, config registers and
// result register pair.
// ----------------------------------------------------------------------------
module lksm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  lksm_pkg::item_t q_item,
	output logic            q_rd,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [9:0]      cfg_data,
	output logic            empty,
	input  logic            pop,
	output lksm_pkg::res_t  res
);

	localparam int ND     = lksm_pkg::NUM_DIGITS;
	localparam int DIG_IW = lksm_pkg::DIG_IW;

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_SETUP    = 4'd1;
	localparam logic [3:0] PH_LOW_HOLD = 4'd2;
	localparam logic [3:0] PH_LOW_DATA = 4'd3;
	localparam logic [3:0] PH_HIGH     = 4'd4;
	localparam logic [3:0] PH_GAP      = 4'd5;
	localparam logic [3:0] PH_TURN     = 4'd6;
	localparam logic [3:0] PH_RX_HIGH  = 4'd7;
	localparam logic [3:0] PH_RX_LOW   = 4'd8;
	localparam logic [3:0] PH_DGAP     = 4'd9;

	localparam logic [1:0] KIND_CMD  = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;
	localparam logic [1:0] KIND_SHOW = 2'd3;

	localparam logic [2:0] REG_WRITE_PHASE = 3'd0;
	localparam logic [2:0] REG_READ_SELECT = 3'd1;
	localparam logic [2:0] REG_READ_CMD    = 3'd2;
	localparam logic [2:0] REG_READ_TURN   = 3'd3;
	localparam logic [2:0] REG_READ_BIT    = 3'd4;

	localparam logic [7:0] DATA_CMD_MASK = 8'hC8;
	localparam logic [7:0] READ_KEY_CMD  = 8'h15;

	logic [9:0] wp_q, rs_q, rc_q, rt_q, rb_q;

	logic [3:0] phase_q, phase_a, phase_n;
	logic [9:0] cnt_q, cnt_a, cnt_n;
	logic [2:0] bit_q, bit_a, bit_n;
	logic [7:0] first_q, first_a, first_n;
	logic [7:0] second_q, second_a, second_n;
	logic [7:0] rx_q, rx_n;
	logic [3:0] pos_q, pos_a, pos_n;
	logic [1:0] kind_q, kind_a;
	logic       level_q, level_a, level_n;
	logic       rel_q, rel_a, rel_n;
	logic       onsec_q, onsec_a, onsec_n;
	logic [3:0] pending_q [ND];

	logic       go, dropped, keyv, dig_wr;
	logic [9:0] len_raw, len;
	logic [10:0] cnt_inc;
	logic [7:0] cur_byte;
	lksm_pkg::res_t res_n;

	lksm_pkg::res_t res_q [2];
	logic           head_q;
	logic [1:0]     ocnt_q;
	logic           out_take;

	assign cfg_ready = 1'b1;
	assign empty     = (ocnt_q == 2'd0);
	assign out_take  = pop && !empty;
	assign go        = q_not_empty && (ocnt_q != 2'd2 || pop);
	assign q_rd      = go;
	assign res       = res_q[head_q];

	always_comb begin
		phase_a  = phase_q;
		cnt_a    = cnt_q;
		bit_a    = bit_q;
		first_a  = first_q;
		second_a = second_q;
		pos_a    = pos_q;
		kind_a   = kind_q;
		level_a  = level_q;
		rel_a    = rel_q;
		onsec_a  = onsec_q;
		dropped  = 1'b0;
		dig_wr   = 1'b0;
		if (q_item.request_valid) begin
			if (phase_q != PH_IDLE) begin
				dropped = 1'b1;
			end else begin
				kind_a = q_item.kind;
				unique case (q_item.kind)
					KIND_CMD: first_a = q_item.command_byte;
					KIND_DATA: begin
						first_a  = q_item.command_byte | DATA_CMD_MASK;
						second_a = q_item.data_byte;
					end
					KIND_READ: first_a = READ_KEY_CMD;
					KIND_SHOW: begin
						dig_wr   = 1'b1;
						pos_a    = '0;
						first_a  = DATA_CMD_MASK;
						second_a = {4'b0, q_item.digits[0]};
					end
				endcase
				level_a = 1'b0;
				rel_a   = 1'b0;
				onsec_a = 1'b0;
				bit_a   = '0;
				cnt_a   = '0;
				phase_a = PH_SETUP;
			end
		end

		if (phase_a == PH_DGAP)
			len_raw = 10'd1;
		else if (kind_a != KIND_READ)
			len_raw = wp_q;
		else begin
			priority case (phase_a)
				PH_SETUP: len_raw = rs_q;
				PH_TURN: len_raw = rt_q;
				PH_RX_HIGH, PH_RX_LOW: len_raw = rb_q;
				default: len_raw = rc_q;
			endcase
		end
		len      = (len_raw == '0) ? 10'd1 : len_raw;
		cnt_inc  = {1'b0, cnt_a} + 11'd1;
		cur_byte = onsec_a ? second_a : first_a;

		phase_n  = phase_a;
		cnt_n    = cnt_a;
		bit_n    = bit_a;
		first_n  = first_a;
		second_n = second_a;
		pos_n    = pos_a;
		level_n  = level_a;
		rel_n    = rel_a;
		onsec_n  = onsec_a;
		rx_n     = rx_q;
		keyv     = 1'b0;

		if (phase_a != PH_IDLE) begin
			if (cnt_inc >= {1'b0, len}) begin
				cnt_n = '0;
				if (phase_a == PH_RX_HIGH)
					second_n = {second_a[6:0], q_item.key_line};
				priority case (phase_a)
					PH_SETUP: phase_n = PH_LOW_HOLD;
					PH_LOW_HOLD: begin
						level_n = cur_byte[3'd7 - bit_a];
						phase_n = PH_LOW_DATA;
					end
					PH_LOW_DATA: phase_n = PH_HIGH;
					PH_HIGH: begin
						if (bit_a != 3'd7) begin
							bit_n   = bit_a + 3'd1;
							phase_n = PH_LOW_HOLD;
						end else begin
							bit_n = '0;
							if (kind_a == KIND_READ) begin
								rel_n    = 1'b1;
								second_n = '0;
								phase_n  = PH_TURN;
							end else if (kind_a != KIND_CMD && !onsec_a) begin
								phase_n = PH_GAP;
							end else if (kind_a == KIND_SHOW
									&& ({1'b0, pos_a} + 5'd1) < 5'(ND)) begin
								pos_n   = pos_a + 4'd1;
								phase_n = PH_DGAP;
							end else begin
								phase_n = PH_IDLE;
							end
						end
					end
					PH_GAP: begin
						onsec_n = 1'b1;
						phase_n = PH_LOW_HOLD;
					end
					PH_TURN: phase_n = PH_RX_HIGH;
					PH_RX_HIGH: phase_n = PH_RX_LOW;
					PH_RX_LOW: begin
						if (bit_a != 3'd7) begin
							bit_n   = bit_a + 3'd1;
							phase_n = PH_RX_HIGH;
						end else begin
							bit_n   = '0;
							rx_n    = second_a;
							phase_n = PH_IDLE;
							keyv    = 1'b1;
						end
					end
					PH_DGAP: begin
						first_n  = 8'(pos_a) | DATA_CMD_MASK;
						second_n = {4'b0, pending_q[pos_a[DIG_IW-1:0]]};
						level_n  = 1'b0;
						rel_n    = 1'b0;
						onsec_n  = 1'b0;
						bit_n    = '0;
						cnt_n    = '0;
						phase_n  = PH_SETUP;
					end
					default: phase_n = PH_IDLE;
				endcase
			end else begin
				cnt_n = cnt_inc[9:0];
			end
		end

		res_n.select_n        = (phase_a == PH_IDLE) || (phase_a == PH_DGAP);
		res_n.serial_clock    = (phase_a == PH_HIGH) || (phase_a == PH_RX_HIGH);
		res_n.serial_data     = rel_a | level_a;
		res_n.drive_enable    = !rel_a;
		res_n.busy_res        = (phase_a != PH_IDLE);
		res_n.key_valid       = keyv;
		res_n.key_code        = rx_n;
		res_n.request_dropped = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 10'd10;
			rs_q <= 10'd1;
			rc_q <= 10'd2;
			rt_q <= 10'd8;
			rb_q <= 10'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WRITE_PHASE: wp_q <= cfg_data;
				REG_READ_SELECT: rs_q <= cfg_data;
				REG_READ_CMD:    rc_q <= cfg_data;
				REG_READ_TURN:   rt_q <= cfg_data;
				REG_READ_BIT:    rb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			bit_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
			rx_q     <= '0;
			pos_q    <= '0;
			kind_q   <= '0;
			level_q  <= 1'b0;
			rel_q    <= 1'b0;
			onsec_q  <= 1'b0;
		end else if (go) begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			bit_q    <= bit_n;
			first_q  <= first_n;
			second_q <= second_n;
			rx_q     <= rx_n;
			pos_q    <= pos_n;
			kind_q   <= kind_a;
			level_q  <= level_n;
			rel_q    <= rel_n;
			onsec_q  <= onsec_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go && dig_wr) begin
			for (int i = 0; i < ND; i++)
				pending_q[i] <= q_item.digits[i];
		end
		if (go)
			res_q[head_q ^ ocnt_q[0]] <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (out_take)
				head_q <= ~head_q;
			if (go && !out_take)
				ocnt_q <= ocnt_q + 2'd1;
			else if (!go && out_take)
				ocnt_q <= ocnt_q - 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> (cnt_q == '0 && bit_q == '0))
		else $error("idle with stale phase counters");
	a_release_read: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE && rel_q) |-> kind_q == KIND_READ)
		else $error("data line released outside a key read");
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result register pair overflow");
`endif

endmodule

FILE: rtl/core/led_keypad_serial_master_top.sv
// ----------------------------------------------------------------------------
// led_keypad_serial_master_top
// Three-wire serial master for an LED display and keypad controller.
// ----------------------------------------------------------------------------
// Each pushed item is one tick of the pin sequence; each tick yields one
// result with the pin levels, busy, key and drop flags. One tick is taken
// every clock cycle as long as results are popped; on its way to its result,
// each tick passes through the digit split pipeline (one divide-by-ten stage
// per digit) and the request queue. Config writes are always ready and must
// only be made while idle.
// ----------------------------------------------------------------------------
module led_keypad_serial_master_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               request_valid,
	input  logic [1:0]         kind,
	input  logic [7:0]         command_byte,
	input  logic [7:0]         data_byte,
	input  logic signed [15:0] value_a,
	input  logic signed [15:0] value_b,
	input  logic               key_line,
	output logic               empty,
	input  logic               pop,
	output logic               select_n,
	output logic               serial_clock,
	output logic               serial_data,
	output logic               drive_enable,
	output logic               busy_res,
	output logic               key_valid,
	output logic [7:0]         key_code,
	output logic               request_dropped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [9:0]         cfg_data
);

	logic            q_wr, q_rd, q_not_empty;
	lksm_pkg::item_t q_wr_item, q_rd_item;
	lksm_pkg::res_t  res;

	lksm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.request_valid (request_valid),
		.kind          (kind),
		.command_byte  (command_byte),
		.data_byte     (data_byte),
		.value_a       (value_a),
		.value_b       (value_b),
		.key_line      (key_line),
		.q_rd          (q_rd),
		.q_wr          (q_wr),
		.q_item        (q_wr_item)
	);

	lksm_req_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (q_wr),
		.wr_item   (q_wr_item),
		.rd_en     (q_rd),
		.rd_item   (q_rd_item),
		.not_empty (q_not_empty)
	);

	lksm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_item      (q_rd_item),
		.q_rd        (q_rd),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.empty       (empty),
		.pop         (pop),
		.res         (res)
	);

	assign select_n        = res.select_n;
	assign serial_clock    = res.serial_clock;
	assign serial_data     = res.serial_data;
	assign drive_enable    = res.drive_enable;
	assign busy_res        = res.busy_res;
	assign key_valid       = res.key_valid;
	assign key_code        = res.key_code;
	assign request_dropped = res.request_dropped;

endmodule

FILE: test/tb_led_keypad_serial_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_keypad_serial_master_top
// Self-checking bench for the display and keypad serial master.
// Every pushed tick runs through a tick-accurate copy of the pin sequencer.
// The copy yields the pin levels, the flags and the key code that the block
// must return for that tick, and each popped result is compared with them in
// order. Directed requests cover byte extremes, key reads, number display,
// drops while busy and zero timing registers. A short stream with no idling
// closes the run, after idle bursts on both sides and back pressure.
// ----------------------------------------------------------------------------
module tb_led_keypad_serial_master_top;

	localparam int unsigned CYCLE_LIMIT = 40000;
	localparam int          DRAIN_SLACK = lksm_pkg::DIGITS_PER_VALUE + 12;
	localparam int          LONG_HOLD   = 250;
	localparam logic [7:0]  CMD_DATA_MASK = 8'hC8;
	localparam logic [7:0]  READ_KEY_CMD  = 8'h15;

	typedef enum logic [1:0] {KIND_CMD, KIND_CMD_DATA, KIND_READ_KEY, KIND_SHOW} req_kind_t;
	typedef enum logic [2:0] {
		REG_WRITE_PHASE, REG_READ_SELECT, REG_READ_CMD_PHASE, REG_READ_TURN, REG_READ_BIT_PHASE
	} reg_idx_t;
	typedef enum logic [3:0] {
		S_IDLE, S_SETUP, S_LOW_HOLD, S_LOW_DATA, S_HIGH, S_GAP, S_TURN, S_RX_HIGH, S_RX_LOW,
		S_DGAP
	} seq_state_t;
	typedef enum logic [1:0] {KEY_RANDOM, KEY_LOW, KEY_HIGH} key_src_t;

	typedef struct packed {
		logic               request_valid;
		req_kind_t          kind;
		logic [7:0]         command_byte;
		logic [7:0]         data_byte;
		logic signed [15:0] value_a;
		logic signed [15:0] value_b;
		logic               key_line;
	} tick_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic               request_valid = 1'b0;
	logic [1:0]         kind = '0;
	logic [7:0]         command_byte = '0;
	logic [7:0]         data_byte = '0;
	logic signed [15:0] value_a = '0;
	logic signed [15:0] value_b = '0;
	logic               key_line = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic               select_n;
	logic               serial_clock;
	logic               serial_data;
	logic               drive_enable;
	logic               busy_res;
	logic               key_valid;
	logic [7:0]         key_code;
	logic               request_dropped;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [9:0]         cfg_data = '0;

	logic [9:0]  t_write = 10'd10;
	logic [9:0]  t_sel = 10'd1;
	logic [9:0]  t_cmd = 10'd2;
	logic [9:0]  t_turn = 10'd8;
	logic [9:0]  t_rxbit = 10'd1;

	seq_state_t  seq_state = S_IDLE;
	int unsigned seq_ticks = 0;
	int unsigned seq_bit = 0;
	logic [7:0]  tx_byte0 = '0;
	logic [7:0]  tx_byte1 = '0;
	logic [7:0]  key_reg = '0;
	logic [3:0]  digit_store [lksm_pkg::NUM_DIGITS];
	int unsigned digit_sel = 0;
	req_kind_t   cur_kind = KIND_CMD;
	logic        dat_lvl = 1'b0;
	logic        dat_released = 1'b0;
	logic        on_byte1 = 1'b0;

	lksm_pkg::res_t pin_levels_due [$];
	int unsigned bad_results = 0;
	int unsigned result_index = 0;
	int unsigned cycle_count = 0;
	int          pop_hold_left = 0;
	int          pop_gap_left = 0;
	logic        idling_on = 1'b1;
	key_src_t    key_src = KEY_RANDOM;

	led_keypad_serial_master_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.request_valid   (request_valid),
		.kind            (kind),
		.command_byte    (command_byte),
		.data_byte       (data_byte),
		.value_a         (value_a),
		.value_b         (value_b),
		.key_line        (key_line),
		.empty           (empty),
		.pop             (pop),
		.select_n        (select_n),
		.serial_clock    (serial_clock),
		.serial_data     (serial_data),
		.drive_enable    (drive_enable),
		.busy_res        (busy_res),
		.key_valid       (key_valid),
		.key_code        (key_code),
		.request_dropped (request_dropped),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void fill_digits(input int unsigned base, input logic [15:0] raw);
		int unsigned mag;
		int unsigned div;
		mag = raw[15] ? 32'h10000 - 32'(raw) : 32'(raw);
		for (int j = 0; j < lksm_pkg::DIGITS_PER_VALUE; j++) begin
			div = 1;
			for (int k = j + 1; k < lksm_pkg::DIGITS_PER_VALUE; k++)
				div *= 10;
			digit_store[base + j] = 4'((mag / div) % 10);
		end
	endfunction

	function automatic void load_digit_write();
		int unsigned p;
		p = digit_sel % lksm_pkg::NUM_DIGITS;
		tx_byte0 = 8'(p) | CMD_DATA_MASK;
		tx_byte1 = {4'h0, digit_store[p]};
	endfunction

	function automatic void start_transfer();
		dat_lvl = 1'b0;
		dat_released = 1'b0;
		on_byte1 = 1'b0;
		seq_bit = 0;
		seq_ticks = 0;
		seq_state = S_SETUP;
	endfunction

	function automatic lksm_pkg::res_t next_pin_levels(input tick_t t);
		lksm_pkg::res_t r;
		int unsigned    len;
		logic [7:0]     cur;
		r = '0;
		if (t.request_valid) begin
			if (seq_state != S_IDLE) begin
				r.request_dropped = 1'b1;
			end else begin
				cur_kind = t.kind;
				case (cur_kind)
					KIND_CMD: tx_byte0 = t.command_byte;
					KIND_CMD_DATA: begin
						tx_byte0 = t.command_byte | CMD_DATA_MASK;
						tx_byte1 = t.data_byte;
					end
					KIND_READ_KEY: tx_byte0 = READ_KEY_CMD;
					default: begin
						fill_digits(0, t.value_a);
						fill_digits(lksm_pkg::DIGITS_PER_VALUE, t.value_b);
						digit_sel = 0;
						load_digit_write();
					end
				endcase
				start_transfer();
			end
		end
		r.busy_res = seq_state != S_IDLE;
		r.select_n = seq_state == S_IDLE || seq_state == S_DGAP;
		r.serial_clock = seq_state == S_HIGH || seq_state == S_RX_HIGH;
		r.drive_enable = !dat_released;
		r.serial_data = dat_released ? 1'b1 : dat_lvl;
		if (r.busy_res) begin
			if (seq_state == S_DGAP)
				len = 1;
			else if (cur_kind != KIND_READ_KEY)
				len = 32'(t_write);
			else begin
				case (seq_state)
					S_SETUP: len = 32'(t_sel);
					S_TURN: len = 32'(t_turn);
					S_RX_HIGH, S_RX_LOW: len = 32'(t_rxbit);
					default: len = 32'(t_cmd);
				endcase
			end
			if (len == 0)
				len = 1;
			seq_ticks++;
			if (seq_ticks >= len) begin
				seq_ticks = 0;
				case (seq_state)
					S_SETUP: seq_state = S_LOW_HOLD;
					S_LOW_HOLD: begin
						cur = on_byte1 ? tx_byte1 : tx_byte0;
						dat_lvl = cur[7 - seq_bit];
						seq_state = S_LOW_DATA;
					end
					S_LOW_DATA: seq_state = S_HIGH;
					S_HIGH: begin
						if (seq_bit < 7) begin
							seq_bit++;
							seq_state = S_LOW_HOLD;
						end else begin
							seq_bit = 0;
							if (cur_kind == KIND_READ_KEY) begin
								dat_released = 1'b1;
								tx_byte1 = '0;
								seq_state = S_TURN;
							end else if (cur_kind != KIND_CMD && !on_byte1) begin
								seq_state = S_GAP;
							end else if (cur_kind == KIND_SHOW
									&& digit_sel + 1 < lksm_pkg::NUM_DIGITS) begin
								digit_sel++;
								seq_state = S_DGAP;
							end else begin
								seq_state = S_IDLE;
							end
						end
					end
					S_GAP: begin
						on_byte1 = 1'b1;
						seq_state = S_LOW_HOLD;
					end
					S_TURN: seq_state = S_RX_HIGH;
					S_RX_HIGH: begin
						tx_byte1 = {tx_byte1[6:0], t.key_line};
						seq_state = S_RX_LOW;
					end
					S_RX_LOW: begin
						if (seq_bit < 7) begin
							seq_bit++;
							seq_state = S_RX_HIGH;
						end else begin
							seq_bit = 0;
							key_reg = tx_byte1;
							seq_state = S_IDLE;
							r.key_valid = 1'b1;
						end
					end
					S_DGAP: begin
						load_digit_write();
						start_transfer();
					end
					default: seq_state = S_IDLE;
				endcase
			end
		end
		r.key_code = key_reg;
		return r;
	endfunction

	always @(posedge clk) begin
		lksm_pkg::res_t want;
		lksm_pkg::res_t got;
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{select_n, serial_clock, serial_data, drive_enable, busy_res, key_valid,
					key_code, request_dropped};
				if (pin_levels_due.size() == 0) begin
					bad_results++;
					if (bad_results <= 10)
						$display("result %0d arrived with nothing due", result_index);
				end else begin
					want = pin_levels_due.pop_front();
					if (got !== want) begin
						bad_results++;
						if (bad_results <= 10)
							$display({"result %0d sel/clk/dat/drv/busy/kv/code/drop ",
								"expected %b %b %b %b %b %b %h %b got %b %b %b %b %b %b %h %b"},
								result_index, want.select_n, want.serial_clock,
								want.serial_data, want.drive_enable, want.busy_res,
								want.key_valid, want.key_code, want.request_dropped,
								got.select_n, got.serial_clock, got.serial_data,
								got.drive_enable, got.busy_res, got.key_valid, got.key_code,
								got.request_dropped);
					end
				end
				result_index++;
			end
			if (pop_hold_left > 0) begin
				pop <= 1'b0;
				pop_hold_left--;
			end else if (pop_gap_left > 0) begin
				pop <= 1'b0;
				pop_gap_left--;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				pop_gap_left = $urandom_range(0, 3);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function automatic tick_t rand_tick(input logic req);
		tick_t t;
		t.request_valid = req;
		t.kind = req_kind_t'($urandom_range(0, 3));
		t.command_byte = 8'($urandom);
		t.data_byte = 8'($urandom);
		t.value_a = 16'($urandom);
		t.value_b = 16'($urandom);
		case (key_src)
			KEY_LOW: t.key_line = 1'b0;
			KEY_HIGH: t.key_line = 1'b1;
			default: t.key_line = 1'($urandom_range(0, 1));
		endcase
		return t;
	endfunction

	function automatic tick_t make_request(input req_kind_t k, input logic [7:0] cmd,
		input logic [7:0] dat, input logic signed [15:0] va, input logic signed [15:0] vb);
		tick_t t;
		t = rand_tick(1'b1);
		t.kind = k;
		t.command_byte = cmd;
		t.data_byte = dat;
		t.value_a = va;
		t.value_b = vb;
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		if (idling_on && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		request_valid <= t.request_valid;
		kind <= t.kind;
		command_byte <= t.command_byte;
		data_byte <= t.data_byte;
		value_a <= t.value_a;
		value_b <= t.value_b;
		key_line <= t.key_line;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pin_levels_due.push_back(next_pin_levels(t));
	endtask

	task automatic run_request(input tick_t req, input int noise_pct);
		send_tick(req);
		while (seq_state != S_IDLE)
			send_tick(rand_tick($urandom_range(0, 99) < noise_pct));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pin_levels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_WRITE_PHASE: t_write = val;
			REG_READ_SELECT: t_sel = val;
			REG_READ_CMD_PHASE: t_cmd = val;
			REG_READ_TURN: t_turn = val;
			default: t_rxbit = val;
		endcase
	endtask

	task automatic set_timing(input logic [9:0] w, input logic [9:0] rs, input logic [9:0] rc,
		input logic [9:0] rt, input logic [9:0] rb);
		wait_drained();
		write_reg(REG_WRITE_PHASE, w);
		write_reg(REG_READ_SELECT, rs);
		write_reg(REG_READ_CMD_PHASE, rc);
		write_reg(REG_READ_TURN, rt);
		write_reg(REG_READ_BIT_PHASE, rb);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_commands();
		set_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
		run_request(make_request(KIND_CMD_DATA, 8'hFF, 8'hFF, '0, '0), 0);
		run_request(make_request(KIND_CMD, 8'h00, 8'h00, '0, '0), 0);
	endtask

	task automatic test_key_reads();
		key_src = KEY_HIGH;
		run_request(make_request(KIND_READ_KEY, 8'h00, 8'h00, '0, '0), 0);
		key_src = KEY_RANDOM;
	endtask

	task automatic test_show_numbers();
		run_request(make_request(KIND_SHOW, 8'h00, 8'h00, 16'sh7FFF, 16'sh8000), 0);
	endtask

	task automatic test_dropped_requests();
		run_request(make_request(KIND_CMD, 8'h81, 8'h7E, '0, '0), 60);
	endtask

	task automatic test_timing_extremes();
		set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		key_src = KEY_LOW;
		run_request(make_request(KIND_READ_KEY, 8'h00, 8'h00, '0, '0), 5);
		key_src = KEY_RANDOM;
		run_request(make_request(KIND_CMD, 8'h96, 8'h00, '0, '0), 5);
	endtask

	task automatic test_back_pressure();
		set_timing(10'd2, 10'd2, 10'd1, 10'd3, 10'd2);
		pop_hold_left = LONG_HOLD;
		run_request(make_request(KIND_READ_KEY, 8'h00, 8'h00, '0, '0), 5);
	endtask

	task automatic test_random_traffic(input int count);
		tick_t t;
		for (int n = 0; n < count; n++) begin
			t = rand_tick(1'b1);
			case ($urandom_range(0, 2))
				0: t.kind = KIND_CMD;
				1: t.kind = KIND_CMD_DATA;
				default: t.kind = KIND_READ_KEY;
			endcase
			run_request(t, 3);
			repeat ($urandom_range(0, 2)) send_tick(rand_tick(1'b0));
		end
	endtask

	task automatic test_steady_stream();
		set_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
		idling_on = 1'b0;
		test_random_traffic(2);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_commands();
		test_key_reads();
		test_show_numbers();
		test_dropped_requests();
		test_timing_extremes();
		test_back_pressure();
		test_steady_stream();
		wait_drained();
		if (bad_results == 0 && pin_levels_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
